[rtl/spi_radio_register_access_assert.svh]
// Assertion macros shared by the radio register access block.
// Clock and reset are the block's own ports: clk_i and rst_ni.
`ifndef SPI_RADIO_REGISTER_ACCESS_ASSERT_SVH
`define SPI_RADIO_REGISTER_ACCESS_ASSERT_SVH

// Same-cycle implication.
`define SRA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sra: same-cycle check failed");

// Next-cycle implication.
`define SRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sra: next-cycle check failed");

`endif

[rtl/sra_pkg.sv]
// ----------------------------------------------------------------------------
// sra_pkg
// Types and codes for the SPI radio register access block.
// ----------------------------------------------------------------------------
package sra_pkg;

  localparam logic [1:0] OpTick   = 2'd0;
  localparam logic [1:0] OpAccess = 2'd1;
  localparam logic [1:0] OpStrobe = 2'd2;
  localparam logic [1:0] OpLoad   = 2'd3;

  localparam logic [2:0] PhIdle    = 3'd0;
  localparam logic [2:0] PhWait    = 3'd1;
  localparam logic [2:0] PhHdrLow  = 3'd2;
  localparam logic [2:0] PhHdrHigh = 3'd3;
  localparam logic [2:0] PhDatLow  = 3'd4;
  localparam logic [2:0] PhDatHigh = 3'd5;
  localparam logic [2:0] PhGap     = 3'd6;

  localparam int unsigned FlRead   = 0;
  localparam int unsigned FlBurst  = 1;
  localparam int unsigned FlStrobe = 2;

  localparam logic [1:0] RxNone   = 2'd0;
  localparam logic [1:0] RxStatus = 2'd1;
  localparam logic [1:0] RxData   = 2'd2;

  localparam logic [7:0] HalfPeriodReset = 8'd1;
  localparam logic [7:0] MsbMask         = 8'h80;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] header;
    logic [7:0] length;
    logic [7:0] wr_data;
    logic       miso;
  } in_word_t;

  typedef struct packed {
    logic       cs_n;
    logic       sclk;
    logic       mosi;
    logic [7:0] rx_byte;
    logic [1:0] rx_kind;
    logic       need_data;
    logic       busy_res;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] tick_count;
    logic [2:0] bit_count;
    logic [7:0] tx_shift;
    logic [7:0] rx_shift;
    logic [7:0] bytes_left;
    logic [2:0] access_flags;
    logic       hold_full;
  } state_t;

endpackage

[rtl/sra_step.sv]
// ----------------------------------------------------------------------------
// sra_step
// Next-state and result logic for one source clock tick.
// ----------------------------------------------------------------------------
module sra_step (
  input  sra_pkg::in_word_t  in_i,
  input  sra_pkg::state_t    st_i,
  input  logic [7:0]         hold_byte_i,
  input  logic [7:0]         half_period_i,
  output sra_pkg::state_t    st_o,
  output logic [7:0]         hold_byte_o,
  output sra_pkg::out_word_t res_o
);

  logic [7:0] h;
  logic [7:0] tick_inc;
  logic       do_next;
  logic       sclk;
  logic       last;
  logic [7:0] rx_byte;
  logic [1:0] rx_kind;

  assign h        = (half_period_i == 8'd0) ? 8'd1 : half_period_i;
  assign tick_inc = st_i.tick_count + 8'd1;

  always_comb begin
    st_o        = st_i;
    hold_byte_o = hold_byte_i;
    do_next     = 1'b0;
    sclk        = 1'b0;
    last        = 1'b0;
    rx_byte     = 8'd0;
    rx_kind     = sra_pkg::RxNone;

    if (in_i.op == sra_pkg::OpLoad) begin
      hold_byte_o  = in_i.wr_data;
      st_o.hold_full = 1'b1;
    end

    unique case (st_i.phase)
      sra_pkg::PhIdle: begin
        if (in_i.op == sra_pkg::OpAccess || in_i.op == sra_pkg::OpStrobe) begin
          st_o.tx_shift     = in_i.header;
          st_o.rx_shift     = 8'd0;
          st_o.tick_count   = 8'd0;
          st_o.bit_count    = 3'd0;
          st_o.access_flags = 3'd0;
          if (in_i.op == sra_pkg::OpStrobe) begin
            st_o.access_flags[sra_pkg::FlStrobe] = 1'b1;
            st_o.bytes_left   = 8'd0;
          end else begin
            st_o.access_flags[sra_pkg::FlRead]  = in_i.header[7];
            st_o.access_flags[sra_pkg::FlBurst] = in_i.header[6];
            st_o.bytes_left   = in_i.header[6] ? in_i.length : 8'd1;
          end
          st_o.phase = sra_pkg::PhWait;
        end
      end
      sra_pkg::PhWait: begin
        if (!in_i.miso) begin
          st_o.phase      = sra_pkg::PhHdrLow;
          st_o.tick_count = 8'd0;
          st_o.bit_count  = 3'd0;
        end
      end
      sra_pkg::PhGap: begin
        do_next = 1'b1;
      end
      sra_pkg::PhHdrLow, sra_pkg::PhDatLow: begin
        st_o.tick_count = tick_inc;
        if (tick_inc >= h) begin
          // rising edge: sample miso
          st_o.tick_count = 8'd0;
          st_o.rx_shift   = {st_i.rx_shift[6:0], in_i.miso};
          st_o.phase      = st_i.phase + 3'd1;
          sclk            = 1'b1;
        end
      end
      sra_pkg::PhHdrHigh, sra_pkg::PhDatHigh: begin
        st_o.tick_count = tick_inc;
        if (tick_inc >= h) begin
          // falling edge: shift out the next bit
          st_o.tick_count = 8'd0;
          st_o.tx_shift   = {st_i.tx_shift[6:0], 1'b0};
          if (st_i.bit_count == 3'd7) begin
            if (st_i.phase == sra_pkg::PhHdrHigh) begin
              rx_byte = st_i.rx_shift;
              rx_kind = sra_pkg::RxStatus;
            end else if (st_i.access_flags[sra_pkg::FlRead]) begin
              rx_byte = st_i.rx_shift;
              rx_kind = sra_pkg::RxData;
            end
            do_next = 1'b1;
          end else begin
            st_o.bit_count = st_i.bit_count + 3'd1;
            st_o.phase     = (st_i.phase == sra_pkg::PhHdrHigh) ? sra_pkg::PhHdrLow
                                                                 : sra_pkg::PhDatLow;
          end
        end else begin
          sclk = 1'b1;
        end
      end
      default: begin
        st_o.phase = sra_pkg::PhIdle;
      end
    endcase

    if (do_next) begin
      priority if (st_o.bytes_left == 8'd0) begin
        st_o.phase = sra_pkg::PhIdle;
        last       = 1'b1;
      end else if (st_o.access_flags[sra_pkg::FlRead]) begin
        st_o.tx_shift   = 8'd0;
        st_o.bytes_left = st_o.bytes_left - 8'd1;
        st_o.phase      = sra_pkg::PhDatLow;
      end else if (st_o.hold_full) begin
        st_o.tx_shift   = hold_byte_o;
        st_o.hold_full  = 1'b0;
        st_o.bytes_left = st_o.bytes_left - 8'd1;
        st_o.phase      = sra_pkg::PhDatLow;
      end else begin
        st_o.phase = sra_pkg::PhGap;
      end
      if (!last) begin
        st_o.tick_count = 8'd0;
        st_o.bit_count  = 3'd0;
      end
    end

    res_o.cs_n      = (st_o.phase == sra_pkg::PhIdle);
    res_o.sclk      = sclk;
    res_o.mosi      = (st_o.phase >= sra_pkg::PhHdrLow && st_o.phase <= sra_pkg::PhDatHigh)
                      ? |(st_o.tx_shift & sra_pkg::MsbMask) : 1'b0;
    res_o.rx_byte   = rx_byte;
    res_o.rx_kind   = rx_kind;
    res_o.need_data = (st_o.phase != sra_pkg::PhIdle) &&
                      !st_o.access_flags[sra_pkg::FlRead] &&
                      !st_o.access_flags[sra_pkg::FlStrobe] &&
                      (st_o.bytes_left != 8'd0) && !st_o.hold_full;
    res_o.busy_res  = (st_o.phase != sra_pkg::PhIdle);
    res_o.last      = last;
  end

endmodule

[rtl/spi_radio_register_access.sv]
// ----------------------------------------------------------------------------
// spi_radio_register_access
// SPI master (mode 0, MSB first) running radio register transactions.
// ----------------------------------------------------------------------------
// Each input word is one tick of the source clock and yields exactly one
// output word carrying the serial pin levels and any received byte. The block
// takes one word per cycle sustained while out_stall_i stays low; each word
// passes through the input register, then the tick logic into the result
// register, where it is offered at the output. The tick logic reads and
// updates the transaction state in the same cycle, so that state loop sets
// the rate. A start word (op 1 register access, op 2 command strobe) drops
// chip select, waits while MISO is high, then shifts the header and returns
// the status byte; reads then return each data byte, writes pull bytes from a
// one-byte holding register (op 3) and raise need_data while it is empty.
// cfg_wdata_i, written with cfg_we_i, sets the serial clock half period in
// ticks (0 acts as 1); write it only while idle.
// ----------------------------------------------------------------------------
`include "spi_radio_register_access_assert.svh"

module spi_radio_register_access (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sra_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sra_pkg::out_word_t out_data_o
);

  logic [7:0]         half_period_q;
  logic               in_valid_q;
  sra_pkg::in_word_t  in_q;
  sra_pkg::state_t    st_q, st_d;
  logic [7:0]         hold_byte_q, hold_byte_d;
  logic               out_valid_q;
  sra_pkg::out_word_t out_q, res_d;
  logic               accept;
  logic               advance;

  // Advance a held tick whenever the result register is free or draining.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= sra_pkg::HalfPeriodReset;
    end else if (cfg_we_i) begin
      half_period_q <= cfg_wdata_i;
    end
  end

  // Input register: hold the word until the tick logic takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  sra_step u_step (
    .in_i          (in_q),
    .st_i          (st_q),
    .hold_byte_i   (hold_byte_q),
    .half_period_i (half_period_q),
    .st_o          (st_d),
    .hold_byte_o   (hold_byte_d),
    .res_o         (res_d)
  );

  // Transaction state moves only when a tick is consumed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // Holding register has no reset; hold_full guards every read.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      hold_byte_q <= hold_byte_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A finished transaction leaves the sequencer idle.
  `SRA_ASSERT_NEXT(a_last_goes_idle, advance && res_d.last, st_q.phase == sra_pkg::PhIdle)
  // A freshly loaded result reports busy exactly when the state is not idle.
  `SRA_ASSERT_NEXT(a_busy_matches, advance, out_q.busy_res == (st_q.phase != sra_pkg::PhIdle))
  // A stalled tick stays in the input register unchanged.
  `SRA_ASSERT_NEXT(a_in_hold, in_valid_q && !advance, in_valid_q && $stable(in_q))
  // Chip select and busy never disagree.
  `SRA_ASSERT_NOW(a_cs_busy, out_valid_q, out_q.cs_n != out_q.busy_res)

endmodule
